// ===== hdl/kdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared constants for the key debounce and press classifier: command codes,
// configuration register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package kdpc_pkg;

  // Default sizes
  localparam int unsigned NUM_KEYS_DEF   = 4;
  localparam int unsigned TICK_WIDTH_DEF = 32;

  // Configuration registers
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd1;
  localparam logic [CFG_W-1:0] SHORT_RST    = 16'd50;

  // Commands
  localparam int unsigned CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_SCAN       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LONG_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LONG_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHORT_TAKE = 2'd3;

  // Per-key state flag positions inside a key slot of the state row
  localparam int unsigned F_STABLE = 0;
  localparam int unsigned F_ACTIVE = 1;
  localparam int unsigned F_HELD   = 2;
  localparam int unsigned F_LONG   = 3;
  localparam int unsigned F_SHORT  = 4;
  localparam int unsigned NUM_FLAGS = 5;

endpackage

// ===== hdl/key_debounce_press_classifier.sv =====
// ----------------------------------------------------------------------------
// key_debounce_press_classifier
// Debounce and short/long press qualifier for a small bank of push keys.
// ----------------------------------------------------------------------------
// One result comes back for every input transfer. The result is registered
// in the output register when stage 1 advances, and a new item can be taken
// every cycle while the output is not stalled. All per-key state (stable
// level, debounce timer, press start, long-taken and short-pending marks)
// sits in one row of a RAM with a registered read: the read is issued at the
// input transfer, the row is updated from the read data and written back
// while the result is loaded into the output register. When a read and
// a write-back land on the same edge, the written row is forwarded, so
// items follow each other without bubbles. A row valid bit stands in for the
// reset of the RAM: until the first write-back the row reads as all zero.
// Command 0 scans the raw keys against now_tick; commands 1..3 pick the
// lowest key set in key_mask and query/consume a long press, clear the
// long-taken mark, or take a pending short press. Tick differences wrap
// modulo 2^TICK_WIDTH. Config registers: index 0 debounce_ticks, index 1
// short_press_ticks; write them only while the block is idle.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier #(
  parameter int unsigned NUM_KEYS   = kdpc_pkg::NUM_KEYS_DEF,
  parameter int unsigned TICK_WIDTH = kdpc_pkg::TICK_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kdpc_pkg::CFG_W-1:0]     cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [kdpc_pkg::CMD_W-1:0]     command_i,
  input  logic [NUM_KEYS-1:0]            raw_keys_i,
  input  logic [TICK_WIDTH-1:0]          now_tick_i,
  input  logic [NUM_KEYS-1:0]            key_mask_i,
  input  logic [TICK_WIDTH-1:0]          hold_ticks_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [NUM_KEYS-1:0]            pressed_keys_o,
  output logic                           event_hit_o
);

  // Row layout: one slot per key, flags then debounce start then press start
  localparam int unsigned NF     = kdpc_pkg::NUM_FLAGS;
  localparam int unsigned KEY_W  = NF + 2 * TICK_WIDTH;
  localparam int unsigned ROW_W  = NUM_KEYS * KEY_W;
  localparam int unsigned DEB_LO = NF;
  localparam int unsigned PRS_LO = NF + TICK_WIDTH;
  localparam int unsigned DEPTH  = 1;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] ROW_ADDR = '0;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [kdpc_pkg::CFG_W-1:0] debounce_q, short_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kdpc_pkg::DEBOUNCE_RST;
      short_q    <= kdpc_pkg::SHORT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kdpc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        kdpc_pkg::CFG_SHORT:    short_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_adv;     // stage 1 moves into the output register
  logic in_xfer;    // input transfer, also the RAM read enable
  logic out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Stage 1 item payload
  logic [kdpc_pkg::CMD_W-1:0] s1_cmd_q;
  logic [NUM_KEYS-1:0]        s1_raw_q, s1_mask_q;
  logic [TICK_WIDTH-1:0]      s1_now_q, s1_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q  <= command_i;
      s1_raw_q  <= raw_keys_i;
      s1_mask_q <= key_mask_i;
      s1_now_q  <= now_tick_i;
      s1_hold_q <= hold_ticks_i;
    end
  end

  // --------------------------------------------------------------------------
  // State RAM with forwarding of a same-edge write-back
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] rdata, cur_row, nxt_row, wdata_q;
  logic             row_valid_q;  // row has been written since reset
  logic             rd_valid_q;   // row was valid when the pending read was issued
  logic             fwd_q;        // pending read raced a write-back

  kdpc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (ROW_ADDR),
    .wdata_i (nxt_row),
    .re_i    (in_xfer),
    .raddr_i (ROW_ADDR),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      if (s1_adv) begin
        row_valid_q <= 1'b1;
      end
      if (in_xfer) begin
        rd_valid_q <= row_valid_q;
        fwd_q      <= s1_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wdata_q <= nxt_row;
    end
  end

  always_comb begin
    if (fwd_q) begin
      cur_row = wdata_q;
    end else if (rd_valid_q) begin
      cur_row = rdata;
    end else begin
      cur_row = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Per-key update lanes
  // --------------------------------------------------------------------------
  logic [NUM_KEYS-1:0]   sel;       // one-hot lowest set bit of the key mask
  logic [NUM_KEYS-1:0]   lane_hit;
  logic [NUM_KEYS-1:0]   stable_nxt;
  logic                  hit;

  assign sel = s1_mask_q & (~s1_mask_q + NUM_KEYS'(1));

  always_comb begin
    logic                  stable, active, held, long_t, short_p, raw;
    logic [TICK_WIDTH-1:0] deb_start, prs_start, deb_el, prs_el;
    nxt_row  = cur_row;
    lane_hit = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      stable    = cur_row[i*KEY_W + kdpc_pkg::F_STABLE];
      active    = cur_row[i*KEY_W + kdpc_pkg::F_ACTIVE];
      held      = cur_row[i*KEY_W + kdpc_pkg::F_HELD];
      long_t    = cur_row[i*KEY_W + kdpc_pkg::F_LONG];
      short_p   = cur_row[i*KEY_W + kdpc_pkg::F_SHORT];
      deb_start = cur_row[i*KEY_W + DEB_LO +: TICK_WIDTH];
      prs_start = cur_row[i*KEY_W + PRS_LO +: TICK_WIDTH];
      raw       = s1_raw_q[i];
      deb_el    = s1_now_q - deb_start;
      prs_el    = s1_now_q - prs_start;

      case (s1_cmd_q)
        kdpc_pkg::CMD_SCAN: begin
          // debounce
          if (raw != stable) begin
            if (!active) begin
              active    = 1'b1;
              deb_start = s1_now_q;
            end else if (deb_el >= TICK_WIDTH'(debounce_q)) begin
              stable = raw;
              active = 1'b0;
            end
          end else begin
            active = 1'b0;
          end
          // press tracking
          if (stable) begin
            if (!held) begin
              prs_start = s1_now_q;
              held      = 1'b1;
              long_t    = 1'b0;
            end
          end else if (held) begin
            if (prs_el >= TICK_WIDTH'(short_q) && !long_t) begin
              short_p = 1'b1;
            end
            held = 1'b0;
          end
        end
        kdpc_pkg::CMD_LONG_QUERY: begin
          if (sel[i] && held && !long_t && prs_el >= s1_hold_q) begin
            long_t      = 1'b1;
            lane_hit[i] = 1'b1;
          end
        end
        kdpc_pkg::CMD_LONG_CLEAR: begin
          if (sel[i]) begin
            long_t = 1'b0;
          end
        end
        kdpc_pkg::CMD_SHORT_TAKE: begin
          if (sel[i] && short_p) begin
            short_p     = 1'b0;
            lane_hit[i] = 1'b1;
          end
        end
        default: ;
      endcase

      nxt_row[i*KEY_W + kdpc_pkg::F_STABLE]   = stable;
      nxt_row[i*KEY_W + kdpc_pkg::F_ACTIVE]   = active;
      nxt_row[i*KEY_W + kdpc_pkg::F_HELD]     = held;
      nxt_row[i*KEY_W + kdpc_pkg::F_LONG]     = long_t;
      nxt_row[i*KEY_W + kdpc_pkg::F_SHORT]    = short_p;
      nxt_row[i*KEY_W + DEB_LO +: TICK_WIDTH] = deb_start;
      nxt_row[i*KEY_W + PRS_LO +: TICK_WIDTH] = prs_start;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      stable_nxt[i] = nxt_row[i*KEY_W + kdpc_pkg::F_STABLE];
    end
  end

  assign hit = |lane_hit;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [NUM_KEYS-1:0] pressed_q;
  logic                hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pressed_q <= stable_nxt;
      hit_q     <= hit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pressed_keys_o = pressed_q;
  assign event_hit_o    = hit_q;

endmodule

// ===== hdl/kdpc_ram.sv =====
// ----------------------------------------------------------------------------
// kdpc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module kdpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/tb_key_debounce_press_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_key_debounce_press_classifier
// Self-checking bench for the four-key debounce and press classifier. Items go
// in over a valid/ready channel. A local copy of the per-key state computes the
// result that each input transfer must produce. A separate process compares
// every result transfer with the oldest predicted one. Directed items cover
// the corners first. Randomized key gestures under several timing settings
// and idle/stall mixes follow, and then a long output hold-off.
// ----------------------------------------------------------------------------
module tb_key_debounce_press_classifier;

  localparam int unsigned KEYS  = kdpc_pkg::NUM_KEYS_DEF;
  localparam int unsigned TICKW = kdpc_pkg::TICK_WIDTH_DEF;
  localparam int unsigned CFGW  = kdpc_pkg::CFG_W;
  localparam int unsigned IDXW  = kdpc_pkg::CFG_IDX_W;
  localparam int unsigned CMDW  = kdpc_pkg::CMD_W;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the output hold-off below.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last result: covers the read/update/write-back
  // pipeline of the state RAM with margin.
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_OFF_LEN   = 300;

  typedef struct packed {
    logic [KEYS-1:0] pressed;
    logic            hit;
  } press_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [IDXW-1:0]      cfg_index_i;
  logic [CFGW-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CMDW-1:0]      command_i;
  logic [KEYS-1:0]      raw_keys_i;
  logic [TICKW-1:0]     now_tick_i;
  logic [KEYS-1:0]      key_mask_i;
  logic [TICKW-1:0]     hold_ticks_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [KEYS-1:0]      pressed_keys_o;
  logic                 event_hit_o;

  key_debounce_press_classifier #(
    .NUM_KEYS  (KEYS),
    .TICK_WIDTH(TICKW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .raw_keys_i    (raw_keys_i),
    .now_tick_i    (now_tick_i),
    .key_mask_i    (key_mask_i),
    .hold_ticks_i  (hold_ticks_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pressed_keys_o(pressed_keys_o),
    .event_hit_o   (event_hit_o)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  press_result_t pending_results[$];   // predicted, not yet seen at the output
  int            fail_count;
  int            in_idle_pct;          // per-cycle chance the sender pauses
  int            out_stall_pct;        // per-cycle chance the receiver stalls
  int            hold_off_left;        // forced receiver hold-off, in cycles
  int            quiet_cycles;
  logic [TICKW-1:0] tick_now;          // running time base for gestures
  int            tick_span;            // max tick advance between scans

  // Mirror of the block's key state and timing registers
  logic [CFGW-1:0]  debounce_len;
  logic [CFGW-1:0]  short_len;
  logic [KEYS-1:0]  key_level;
  logic [KEYS-1:0]  bounce_timing;
  logic [TICKW-1:0] bounce_t0 [KEYS];
  logic [KEYS-1:0]  key_held;
  logic [TICKW-1:0] press_t0 [KEYS];
  logic [KEYS-1:0]  long_consumed;
  logic [KEYS-1:0]  short_latched;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Press classifier prediction: applies one accepted item to the key state
  // mirror and queues the result it must produce.
  // --------------------------------------------------------------------------
  task automatic classify_item(input logic [CMDW-1:0] cmd, input logic [KEYS-1:0] raw,
                               input logic [TICKW-1:0] now, input logic [KEYS-1:0] mask,
                               input logic [TICKW-1:0] hold);
    press_result_t res;
    logic [TICKW-1:0] age;
    int k;
    int sel;
    res.hit = 1'b0;
    sel = -1;
    if (cmd == kdpc_pkg::CMD_SCAN) begin
      for (k = 0; k < KEYS; k++) begin
        // debounce: a new raw level only arms the timer, a later scan commits it
        if (raw[k] != key_level[k]) begin
          if (!bounce_timing[k]) begin
            bounce_timing[k] = 1'b1;
            bounce_t0[k]     = now;
          end else begin
            age = now - bounce_t0[k];
            if (age >= TICKW'(debounce_len)) begin
              key_level[k]     = raw[k];
              bounce_timing[k] = 1'b0;
            end
          end
        end else begin
          bounce_timing[k] = 1'b0;
        end
        // press tracking on the stable level
        if (key_level[k]) begin
          if (!key_held[k]) begin
            press_t0[k]      = now;
            key_held[k]      = 1'b1;
            long_consumed[k] = 1'b0;
          end
        end else if (key_held[k]) begin
          age = now - press_t0[k];
          if (age >= TICKW'(short_len) && !long_consumed[k]) short_latched[k] = 1'b1;
          key_held[k] = 1'b0;
        end
      end
    end else begin
      // lowest set mask bit wins
      for (k = KEYS - 1; k >= 0; k--) begin
        if (mask[k]) sel = k;
      end
      if (sel >= 0) begin
        case (cmd)
          kdpc_pkg::CMD_LONG_QUERY: begin
            age = now - press_t0[sel];
            if (key_held[sel] && !long_consumed[sel] && age >= hold) begin
              long_consumed[sel] = 1'b1;
              res.hit = 1'b1;
            end
          end
          kdpc_pkg::CMD_LONG_CLEAR: long_consumed[sel] = 1'b0;
          default: begin
            if (short_latched[sel]) begin
              short_latched[sel] = 1'b0;
              res.hit = 1'b1;
            end
          end
        endcase
      end
    end
    res.pressed = key_level;
    pending_results.push_back(res);
  endtask

  task automatic clear_key_state();
    int k;
    debounce_len  = kdpc_pkg::DEBOUNCE_RST;
    short_len     = kdpc_pkg::SHORT_RST;
    key_level     = '0;
    bounce_timing = '0;
    key_held      = '0;
    long_consumed = '0;
    short_latched = '0;
    for (k = 0; k < KEYS; k++) begin
      bounce_t0[k] = '0;
      press_t0[k]  = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: one item per call. Entered right after a rising edge. Valid stays
  // up across back-to-back items and drops only when a pause is taken.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [CMDW-1:0] cmd, input logic [KEYS-1:0] raw,
                           input logic [TICKW-1:0] now, input logic [KEYS-1:0] mask,
                           input logic [TICKW-1:0] hold);
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    raw_keys_i   <= raw;
    now_tick_i   <= now;
    key_mask_i   <= mask;
    hold_ticks_i <= hold;
    do @(posedge clk_i); while (!in_ready_o);
    classify_item(cmd, raw, now, mask, hold);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
  endtask

  // Drop valid and wait for every predicted result to come out, then let the
  // pipeline settle so the block is truly idle.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      kdpc_pkg::CFG_DEBOUNCE: debounce_len = val;
      default:                short_len    = val;
    endcase
  endtask

  // Both timing registers, written only with the block idle
  task automatic set_timing(input logic [CFGW-1:0] dbn, input logic [CFGW-1:0] shrt);
    wait_results_drained();
    write_reg(kdpc_pkg::CFG_DEBOUNCE, dbn);
    write_reg(kdpc_pkg::CFG_SHORT, shrt);
    cfg_valid_i <= 1'b0;
    // gestures advance time in steps that fit the debounce and press lengths
    tick_span = ((dbn > shrt) ? int'(dbn) : int'(shrt)) / 3 + 4;
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  function automatic logic [TICKW-1:0] pick_hold();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return $urandom;
      default: return $urandom_range(0, 6 * tick_span);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random gestures: mostly keys held in a pattern over several scans with a
  // coherent time base and some bounce, mixed with queries at the current
  // time, plus a share of fully random items.
  // --------------------------------------------------------------------------
  task automatic play_gestures(input int n_items);
    int sent;
    int reps;
    int r;
    logic [KEYS-1:0]  target;
    logic [KEYS-1:0]  raw;
    logic [KEYS-1:0]  mask;
    logic [CMDW-1:0]  cmd;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(CMDW'($urandom_range(3)), KEYS'($urandom_range(15)), $urandom,
                  KEYS'($urandom_range(15)), $urandom);
        sent++;
      end else if (r < 40) begin
        case ($urandom_range(2))
          0:       cmd = kdpc_pkg::CMD_LONG_QUERY;
          1:       cmd = kdpc_pkg::CMD_LONG_CLEAR;
          default: cmd = kdpc_pkg::CMD_SHORT_TAKE;
        endcase
        // mostly one key, sometimes any mask, the empty one included
        if ($urandom_range(3) == 0) mask = KEYS'($urandom_range(15));
        else mask = KEYS'(1) << $urandom_range(KEYS - 1);
        tick_now += $urandom_range(0, tick_span / 2);
        send_item(cmd, KEYS'($urandom_range(15)), tick_now, mask, pick_hold());
        sent++;
      end else begin
        target = KEYS'($urandom_range(15));
        reps   = $urandom_range(1, 6);
        repeat (reps) begin
          tick_now += $urandom_range(0, tick_span);
          raw = target;
          if ($urandom_range(4) == 0) raw ^= KEYS'(1) << $urandom_range(KEYS - 1);
          send_item(kdpc_pkg::CMD_SCAN, raw, tick_now, KEYS'($urandom_range(15)),
                    $urandom);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset timing (debounce 1, short 50): first differing scan only arms the
  // timer, a scan at zero elapsed does not commit, one tick later does.
  task automatic test_reset_state();
    set_idling(0, 0);
    send_item(kdpc_pkg::CMD_SHORT_TAKE, 4'hF, 32'd10, 4'hF, 32'd0);
    send_item(kdpc_pkg::CMD_SCAN, 4'hF, 32'd10, 4'h0, 32'd0);
    send_item(kdpc_pkg::CMD_SCAN, 4'hF, 32'd10, 4'h0, 32'd0);
    send_item(kdpc_pkg::CMD_SCAN, 4'hF, 32'd11, 4'h0, 32'd0);
  endtask

  // Zero debounce and zero short length; long query, mark clear, short take,
  // empty mask and the timer stop when the level returns.
  task automatic test_debounce_and_queries();
    set_timing('0, '0);
    // keys are already pressed: release is first staged, then restart
    send_item(kdpc_pkg::CMD_SCAN, 4'h0, 32'd20, 4'hF, 32'hFFFF_FFFF);
    send_item(kdpc_pkg::CMD_SCAN, 4'h0, 32'd20, 4'h0, 32'd0);       // commits release
    send_item(kdpc_pkg::CMD_SCAN, 4'hF, 32'd30, 4'h0, 32'd0);       // arms at zero debounce
    send_item(kdpc_pkg::CMD_SCAN, 4'hF, 32'd30, 4'h0, 32'd0);       // press accepted
    send_item(kdpc_pkg::CMD_LONG_QUERY, 4'h5, 32'd31, 4'h0, 32'd0); // empty mask: nothing
    send_item(kdpc_pkg::CMD_LONG_QUERY, 4'h0, 32'd31, 4'hA, 32'd0); // picks key 1
    send_item(kdpc_pkg::CMD_LONG_QUERY, 4'hF, 32'd32, 4'h2, 32'd0); // already consumed
    send_item(kdpc_pkg::CMD_LONG_CLEAR, 4'h0, 32'd32, 4'h2, 32'd0);
    send_item(kdpc_pkg::CMD_LONG_QUERY, 4'h0, 32'd33, 4'h2, 32'hFFFF_FFFF);
    send_item(kdpc_pkg::CMD_LONG_QUERY, 4'h0, 32'd33, 4'h2, 32'd3);
    send_item(kdpc_pkg::CMD_SCAN, 4'h0, 32'd35, 4'hF, 32'd0);       // arms release, all keys
    send_item(kdpc_pkg::CMD_SCAN, 4'h5, 32'd36, 4'hF, 32'd0);       // keys 0,2 back: stop
    send_item(kdpc_pkg::CMD_SHORT_TAKE, 4'h0, 32'd37, 4'h8, 32'd0);
    send_item(kdpc_pkg::CMD_SHORT_TAKE, 4'h0, 32'd37, 4'h8, 32'd0);
    send_item(kdpc_pkg::CMD_SHORT_TAKE, 4'h0, 32'd37, 4'h2, 32'd0); // long taken, no short
  endtask

  // Largest timing values with the tick counter wrapping through zero
  task automatic test_tick_wrap();
    set_timing('1, '1);
    send_item(kdpc_pkg::CMD_SCAN, 4'h1, 32'hFFFF_FFF0, 4'h0, 32'd0);
    send_item(kdpc_pkg::CMD_SCAN, 4'h1, 32'h0000_FFEE, 4'h0, 32'd0); // one short of debounce
    send_item(kdpc_pkg::CMD_SCAN, 4'h1, 32'h0000_FFEF, 4'h0, 32'd0);
    send_item(kdpc_pkg::CMD_LONG_QUERY, 4'h0, 32'h0001_FFEF, 4'h1, 32'h0001_0000);
    send_item(kdpc_pkg::CMD_SCAN, 4'h0, 32'h0002_0000, 4'h0, 32'd0);
    send_item(kdpc_pkg::CMD_SCAN, 4'h0, 32'h0003_0000, 4'h0, 32'd0);
  endtask

  task automatic test_random_traffic(input int in_pct, input int out_pct,
                                     input logic [CFGW-1:0] dbn,
                                     input logic [CFGW-1:0] shrt, input int n_items);
    set_timing(dbn, shrt);
    set_idling(in_pct, out_pct);
    play_gestures(n_items);
  endtask

  // Receiver held off while the sender keeps offering: the block fills up and
  // must stall its input without losing or reordering anything.
  task automatic test_backpressure();
    set_timing(16'd3, 16'd40);
    set_idling(0, 0);
    hold_off_left = HOLD_OFF_LEN;
    play_gestures(40);
  endtask

  // --------------------------------------------------------------------------
  // Receiver ready: random stalls, or a forced hold-off counted down here
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    press_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing predicted: pressed_keys %h event_hit %b",
               pressed_keys_o, event_hit_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (pressed_keys_o !== want.pressed) begin
          $error("pressed_keys: expected %h, actual %h", want.pressed, pressed_keys_o);
          fail_count++;
        end
        if (event_hit_o !== want.hit) begin
          $error("event_hit: expected %b, actual %b", want.hit, event_hit_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles with no transfer on any channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = kdpc_pkg::CMD_SCAN;
    raw_keys_i    = '0;
    now_tick_i    = '0;
    key_mask_i    = '0;
    hold_ticks_i  = '0;
    out_ready_i   = 1'b0;
    fail_count    = 0;
    quiet_cycles  = 0;
    hold_off_left = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    tick_now      = $urandom;
    tick_span     = int'(kdpc_pkg::SHORT_RST) / 3 + 4;
    clear_key_state();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_debounce_and_queries();
    test_tick_wrap();
    test_random_traffic(0, 0, kdpc_pkg::DEBOUNCE_RST, kdpc_pkg::SHORT_RST, 130);
    test_random_traffic(83, 0, '0, '0, 110);
    test_random_traffic(0, 83, CFGW'($urandom_range(0, 20)), CFGW'($urandom_range(0, 200)),
                        110);
    test_random_traffic(32, 32, '1, '1, 110);
    test_backpressure();
    wait_results_drained();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kdpc_pkg.sv
hdl/kdpc_ram.sv
hdl/key_debounce_press_classifier.sv
test/tb_key_debounce_press_classifier.sv
